// ----- design/assert_macros.svh -----
// Assertion macros shared by the min tracking stack RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define MTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// cond must never be true outside reset
`define MTS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define MTS_ASSERT(label, clk, rst, prop, msg)
`define MTS_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- design/mts_pkg.sv -----
// Shared types and constants for the min tracking stack.
// No dependencies; used by mts_ctrl, mts_datapath and min_tracking_stack.
package mts_pkg;

   localparam int unsigned DEPTH  = 1024;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   localparam logic [1:0] CMD_QUERY = 2'd0;
   localparam logic [1:0] CMD_PUSH  = 2'd1;
   localparam logic [1:0] CMD_POP   = 2'd2;

   localparam logic signed [31:0] EMPTY_CODE = -32'sd1;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic signed [31:0] min_value;
      logic               is_empty;
      logic               is_full;
      logic               ignored;
   } rsp_type;

   // one stored entry: its value and the minimum of it and all below
   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] min_below;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;  // item accepted this cycle
      logic load;  // refill top cache from memory read data
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic refill;  // offered item is a pop that exposes a stored entry
   } dp_status_type;

endpackage

// ----- design/min_tracking_stack.sv -----
// Top level of the min tracking stack: controller plus datapath.
// Depends on mts_pkg, mts_ctrl and mts_datapath.
//
// Bounded LIFO of signed 32-bit values that also reports the least stored value.
// Input: req_item (command, push_value) is taken at a clock edge where start is
// high and busy is low. Command 1 pushes, 2 pops, 0 and 3 only query.
// Output: one result per item, shown for one cycle with rsp_strobe high:
// top entry and minimum (both -1 when empty), empty, full and ignored flags.
// The receiver cannot stall; a result must be taken in its strobe cycle.
// For push and query the result appears the cycle after acceptance; a pop
// that leaves entries on the stack passes through ST_LOAD before ST_RESP.
// While in ST_LOAD busy is high and no new item is taken; the load refills the top
// cache from the registered read of the new top entry in the entry memory.
// A new item may be offered in the cycle its predecessor's result is shown.
// Each entry holds its value and the minimum of it and all entries below, so the top
// cache registers carry both answers whenever a result is shown.
// Reset empties the stack at once; no memory clearing pass is needed.
module min_tracking_stack (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mts_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output mts_pkg::rsp_type  rsp_item
);
   import mts_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (dp_status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .dp_cmd     (dp_cmd)
   );

   mts_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .dp_cmd   (dp_cmd),
      .req_item (req_item),
      .status   (dp_status),
      .rsp_item (rsp_item)
   );

endmodule

// ----- design/mts_ctrl.sv -----
// Controller state machine of the min tracking stack.
// Depends on mts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mts_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mts_pkg::dp_status_type     status,
   output logic                       busy,
   output logic                       rsp_strobe,
   output mts_pkg::dp_cmd_type        dp_cmd
);
   import mts_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (accept) begin
               state_in = status.refill ? ST_LOAD : ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            state_in = ST_RESP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b0;
      rsp_strobe  = 1'b0;
      dp_cmd.load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LOAD: begin
            busy        = 1'b1;
            dp_cmd.load = 1'b1;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
      dp_cmd.exec = start && !busy;
   end

   // a refill always ends in exactly one result
   `MTS_ASSERT(a_load_then_resp, clock, reset,
      (state_ff == ST_LOAD) |=> (state_ff == ST_RESP), "load not followed by result")
   `MTS_ASSERT(a_refill_goes_load, clock, reset,
      (accept && status.refill) |=> (state_ff == ST_LOAD), "pop refill skipped load")
   `MTS_ASSERT(a_accept_gives_result, clock, reset,
      (accept && !status.refill) |=> rsp_strobe, "item without result")

endmodule

// ----- design/mts_datapath.sv -----
// Datapath of the min tracking stack: entry memory, count, top-of-stack cache.
// Depends on mts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mts_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  mts_pkg::dp_cmd_type        dp_cmd,
   input  mts_pkg::req_type           req_item,
   output mts_pkg::dp_status_type     status,
   output mts_pkg::rsp_type           rsp_item
);
   import mts_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic signed [31:0]  top_ff;
   logic signed [31:0]  top_in;
   logic signed [31:0]  min_ff;
   logic signed [31:0]  min_in;
   logic                ignored_ff;
   logic                ignored_in;

   logic                empty;
   logic                full;
   logic                wr_en;
   logic signed [31:0]  new_min;
   logic [CNT_W-1:0]    rd_count;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign new_min  = (!empty && (min_ff < req_item.push_value)) ? min_ff : req_item.push_value;
   assign wr_en    = dp_cmd.exec && (req_item.command == CMD_PUSH) && !full;
   assign wr_addr  = count_ff[ADDR_W-1:0];
   // entry under the current top; only used when at least two are stored
   assign rd_count = count_ff - CNT_W'(2);
   assign rd_addr  = rd_count[ADDR_W-1:0];

   assign status.refill = (req_item.command == CMD_POP) && (count_ff > CNT_W'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{value: req_item.push_value, min_below: new_min};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in   = count_ff;
      top_in     = top_ff;
      min_in     = min_ff;
      ignored_in = ignored_ff;
      if (dp_cmd.exec) begin
         ignored_in = 1'b0;
         case (req_item.command)
            CMD_PUSH: begin
               if (full) begin
                  ignored_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  top_in   = req_item.push_value;
                  min_in   = new_min;
               end
            end
            CMD_POP: begin
               if (empty) begin
                  ignored_in = 1'b1;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end else if (dp_cmd.load) begin
         top_in = rd_data_ff.value;
         min_in = rd_data_ff.min_below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ignored_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         ignored_ff <= ignored_in;
      end
      top_ff <= top_in;
      min_ff <= min_in;
   end

   always_comb begin
      rsp_item.top_value = empty ? EMPTY_CODE : top_ff;
      rsp_item.min_value = empty ? EMPTY_CODE : min_ff;
      rsp_item.is_empty  = empty;
      rsp_item.is_full   = full;
      rsp_item.ignored   = ignored_ff;
   end

   `MTS_ASSERT_NEVER(a_count_bound, clock, reset,
      count_ff > CNT_W'(DEPTH), "entry count beyond depth")
   `MTS_ASSERT(a_push_counts, clock, reset,
      wr_en |=> (count_ff == $past(count_ff) + CNT_W'(1)), "push did not grow stack")
   `MTS_ASSERT(a_min_not_above_top, clock, reset,
      (dp_cmd.exec && !empty && !dp_cmd.load) |-> (min_ff <= top_ff), "cached min above top")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for min_tracking_stack: pushes, pops and queries with bursty start.
// Depends on mts_pkg and the min_tracking_stack RTL; a small class predicts and checks.
module tb;
   import mts_pkg::*;

   // command 3 has no package name; the block treats it as a query
   localparam logic [1:0] CMD_SPARE  = 2'd3;
   localparam int unsigned STALL_LIMIT = 400;

   class stack_scoreboard;
      logic signed [31:0] entry_val [DEPTH];
      logic signed [31:0] entry_min [DEPTH];
      int unsigned        level;
      rsp_type            expected_q[$];
      int unsigned        mismatches;
      int unsigned        results_seen;
      int unsigned        pushes;
      int unsigned        pops;
      int unsigned        dropped;
      int unsigned        full_results;
      int unsigned        peak;

      function new();
         level = 0;
         mismatches = 0;
         results_seen = 0;
         pushes = 0;
         pops = 0;
         dropped = 0;
         full_results = 0;
         peak = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // apply one accepted item to the shadow stack and queue its result
      function void note_item(req_type it);
         rsp_type            e;
         logic signed [31:0] m;
         e.ignored = 1'b0;
         case (it.command)
            CMD_PUSH: begin
               if (level == DEPTH) begin
                  e.ignored = 1'b1;
               end else begin
                  m = it.push_value;
                  if (level > 0 && entry_min[level-1] < m)
                     m = entry_min[level-1];
                  entry_val[level] = it.push_value;
                  entry_min[level] = m;
                  level++;
                  pushes++;
               end
            end
            CMD_POP: begin
               if (level == 0) begin
                  e.ignored = 1'b1;
               end else begin
                  level--;
                  pops++;
               end
            end
            default: ;
         endcase
         if (level == 0) begin
            e.top_value = EMPTY_CODE;
            e.min_value = EMPTY_CODE;
            e.is_empty  = 1'b1;
         end else begin
            e.top_value = entry_val[level-1];
            e.min_value = entry_min[level-1];
            e.is_empty  = 1'b0;
         end
         e.is_full = (level == DEPTH);
         if (e.ignored) dropped++;
         if (e.is_full) full_results++;
         if (level > peak) peak = level;
         expected_q.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with no item pending: top %0d min %0d e%0b f%0b i%0b",
                        got.top_value, got.min_value, got.is_empty, got.is_full, got.ignored);
            return;
         end
         e = expected_q.pop_front();
         if (got.top_value !== e.top_value || got.min_value !== e.min_value ||
             got.is_empty !== e.is_empty || got.is_full !== e.is_full ||
             got.ignored !== e.ignored) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d: exp top %0d min %0d e%0b f%0b i%0b",
                        results_seen, e.top_value, e.min_value,
                        e.is_empty, e.is_full, e.ignored);
               $display("       got top %0d min %0d e%0b f%0b i%0b",
                        got.top_value, got.min_value, got.is_empty, got.is_full,
                        got.ignored);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   stack_scoreboard sb;
   int unsigned     burst_left;
   int unsigned     items_sent;
   int unsigned     gen_level;
   int unsigned     idle_cycles;

   min_tracking_stack u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // results are checked before the item taken at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_item);
         if (start && !busy) sb.note_item(req_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no activity for %0d cycles, %0d results pending",
                     STALL_LIMIT, sb.pending());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // offer one item and hold it until taken; bursts end with a random gap
   task automatic issue(input logic [1:0] cmd, input logic signed [31:0] val);
      req_type it;
      it.command    = cmd;
      it.push_value = val;
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (cmd == CMD_PUSH && gen_level < DEPTH) gen_level++;
      else if (cmd == CMD_POP && gen_level > 0) gen_level--;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // extremes, -1, values near the bottom, small clustered values, full range
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return EMPTY_CODE;
         3: return 32'sh8000_0000 + $urandom_range(0, 1023);
         4, 5: return $signed($urandom_range(0, 40)) - 20;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_op(input int unsigned push_pct, input int unsigned pop_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < push_pct)
         issue(CMD_PUSH, pick_value());
      else if (r < push_pct + pop_pct)
         issue(CMD_POP, $urandom);
      else
         issue($urandom_range(0, 1) ? CMD_QUERY : CMD_SPARE, $urandom);
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      burst_left = 5;
      items_sent = 0;
      gen_level  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty stack, extremes, -1 that looks like empty, equal minima
      issue(CMD_QUERY, 32'sh7fff_ffff);
      issue(CMD_POP,   32'sh0);
      issue(CMD_SPARE, 32'sh8000_0000);
      issue(CMD_PUSH,  32'sh7fff_ffff);
      issue(CMD_PUSH,  32'sh8000_0000);
      issue(CMD_PUSH,  EMPTY_CODE);
      issue(CMD_PUSH,  32'sh0);
      issue(CMD_QUERY, EMPTY_CODE);
      issue(CMD_POP,   32'sh5555_5555);
      issue(CMD_POP,   32'shaaaa_aaaa);
      issue(CMD_POP,   32'sh0);
      issue(CMD_POP,   32'sh0);
      issue(CMD_POP,   32'sh0);
      issue(CMD_PUSH,  EMPTY_CODE);
      issue(CMD_SPARE, EMPTY_CODE);
      issue(CMD_POP,   32'sh0);
      issue(CMD_PUSH,  32'sd5);
      issue(CMD_PUSH,  32'sd5);
      issue(CMD_PUSH,  32'sd3);
      issue(CMD_PUSH,  32'sd7);
      issue(CMD_POP,   32'sh0);
      issue(CMD_POP,   32'sh0);
      issue(CMD_POP,   32'sh0);
      issue(CMD_POP,   32'sh0);
      wait_drained();

      // near empty: many dropped pops
      repeat (150) random_op(45, 45);

      // fill to full, then hammer the full boundary
      while (gen_level < DEPTH) random_op(97, 2);
      repeat (40) random_op(60, 20);
      wait_drained();

      // drain a good way down so stored minima get exposed again
      while (gen_level > DEPTH - 200) random_op(4, 93);
      repeat (40) random_op(40, 40);

      wait_drained();
      repeat (4) @(posedge clock);

      $display("ran %0d items: %0d pushes, %0d pops, %0d dropped, peak depth %0d",
               items_sent, sb.pushes, sb.pops, sb.dropped, sb.peak);
      $display("%0d results checked, %0d while full, %0d mismatches, %0d left pending",
               sb.results_seen, sb.full_results, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
